>>> rtl/mrxy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrxy_pkg;

   // Port numbering, shared by arrival ports, output ports and bit masks
   localparam int NUM_PORTS = 5;
   localparam int PORT_N = 0;
   localparam int PORT_S = 1;
   localparam int PORT_E = 2;
   localparam int PORT_W = 3;
   localparam int PORT_L = 4;

   // Fixed field widths of the request and response channels
   localparam int PORT_IDX_W = 3;
   localparam int COORD_W    = 8;
   localparam int PAYLOAD_W  = 64;
   localparam int STAMP_W    = 32;

   // Default sizing of the internal storage
   localparam int COORD_BITS_DEF   = 8;
   localparam int STAMP_BITS_DEF   = 32;
   localparam int PAYLOAD_BITS_DEF = 64;

   // Request codes
   localparam logic REQ_RECV = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Response kinds
   localparam logic [1:0] KIND_RECV = 2'd0;
   localparam logic [1:0] KIND_FWD  = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;
   localparam logic [1:0] KIND_DROP = 2'd3;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_X        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_Y        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_PRESENT = 2'd2;
   localparam logic [NUM_PORTS-1:0]   PORT_PRESENT_RST = 5'b11111;

   typedef struct packed {
      logic                   req_type;
      logic [PORT_IDX_W-1:0]  in_port;
      logic [COORD_W-1:0]     dest_x;
      logic [COORD_W-1:0]     dest_y;
      logic [PAYLOAD_W-1:0]   payload;
      logic [STAMP_W-1:0]     stamp_in;
      logic [NUM_PORTS-1:0]   out_ready;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic                   accepted;
      logic [PORT_IDX_W-1:0]  out_port;
      logic [COORD_W-1:0]     out_dest_x;
      logic [COORD_W-1:0]     out_dest_y;
      logic [PAYLOAD_W-1:0]   out_payload;
      logic [STAMP_W-1:0]     out_stamp;
      logic                   last;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/mesh_router_xy_oldest_first_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   mrxy_pkg::req_item_type
// rsp_      out        rsp_valid/rsp_stall   mrxy_pkg::rsp_item_type
// csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// A request is routed in the cycle it is accepted; slot and counter state update at that edge.
// A receive gives one response, a tick gives one to five; responses sit in five lanes and
// drain one per cycle, when rsp_stall does not hold them, into the response register; the
// lanes are written when the request is accepted. The next request is taken once the lanes
// are empty or their last response is leaving, so a request holds off the next until its
// responses have drained, response stalls included. Reset is synchronous.
module mesh_router_xy_oldest_first_unit #(
   parameter int COORD_BITS   = mrxy_pkg::COORD_BITS_DEF,
   parameter int STAMP_BITS   = mrxy_pkg::STAMP_BITS_DEF,
   parameter int PAYLOAD_BITS = mrxy_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire mrxy_pkg::req_item_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output mrxy_pkg::rsp_item_type                   rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mrxy_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mrxy_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NP = mrxy_pkg::NUM_PORTS;
   localparam int PW = mrxy_pkg::PORT_IDX_W;
   localparam int CW = mrxy_pkg::COORD_W;
   localparam int DW = mrxy_pkg::PAYLOAD_W;
   localparam int SW = mrxy_pkg::STAMP_W;

   // Configuration
   logic [CW-1:0]             own_x_ff;
   logic [CW-1:0]             own_y_ff;
   logic [NP-1:0]             port_present_ff;

   // Router state
   logic [STAMP_BITS-1:0]     cycle_count_ff;
   logic [STAMP_BITS-1:0]     cycle_count_in;
   logic [NP-1:0]             slot_busy_ff;
   logic [NP-1:0]             slot_busy_in;
   logic [COORD_BITS-1:0]     slot_dx_ff [NP];
   logic [COORD_BITS-1:0]     slot_dy_ff [NP];
   logic [PAYLOAD_BITS-1:0]   slot_payload_ff [NP];
   logic [STAMP_BITS-1:0]     slot_stamp_ff [NP];

   // Response lanes and response register
   mrxy_pkg::rsp_item_type    pend_ff [NP];
   logic [NP-1:0]             pend_valid_ff;
   logic [NP-1:0]             pend_valid_in;
   mrxy_pkg::rsp_item_type    rsp_data_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   // Combinational
   logic                      req_accept;
   logic                      is_tick;
   logic                      tick_accept;
   logic [NP-1:0]             rec_hit;
   logic                      rec_ok;
   logic [NP-1:0]             store_en;
   logic [COORD_BITS-1:0]     own_xc;
   logic [COORD_BITS-1:0]     own_yc;
   logic [NP-1:0]             dir [NP];
   logic [NP-1:0]             win;
   logic [NP-1:0]             has_win;
   logic [NP-1:0]             emit;
   logic [NP-1:0]             free;
   logic [COORD_BITS-1:0]     w_dx [NP];
   logic [COORD_BITS-1:0]     w_dy [NP];
   logic [PAYLOAD_BITS-1:0]   w_payload [NP];
   logic [STAMP_BITS-1:0]     w_stamp [NP];
   mrxy_pkg::rsp_item_type    new_lane [NP];
   logic [NP-1:0]             new_valid;
   logic [NP-1:0]             sel_oh;
   logic                      pend_any;
   logic                      drain_last;
   logic                      move;
   mrxy_pkg::rsp_item_type    sel_item;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // Lane drain into the response register
   assign pend_any    = (pend_valid_ff != '0);
   assign sel_oh      = pend_valid_ff & (~pend_valid_ff + 1'b1);
   assign drain_last  = ((pend_valid_ff & ~sel_oh) == '0);
   assign move        = pend_any && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = !(!pend_any || (drain_last && move));

   assign req_accept  = req_valid && !req_stall;
   assign is_tick     = (req_data.req_type == mrxy_pkg::REQ_TICK);
   assign tick_accept = req_accept && is_tick;

   assign own_xc      = COORD_BITS'(own_x_ff);
   assign own_yc      = COORD_BITS'(own_y_ff);

   // Find which slot a receive lands in
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         rec_hit[i]  = (req_data.in_port == PW'(i)) && !slot_busy_ff[i];
         store_en[i] = req_accept && !is_tick && rec_hit[i];
      end
      rec_ok = (rec_hit != '0);
   end

   // Route each slot in XY order
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         dir[i] = '0;
         if (slot_dx_ff[i] < own_xc) begin
            dir[i][mrxy_pkg::PORT_W] = 1'b1;
         end else if (slot_dx_ff[i] > own_xc) begin
            dir[i][mrxy_pkg::PORT_E] = 1'b1;
         end else if (slot_dy_ff[i] < own_yc) begin
            dir[i][mrxy_pkg::PORT_S] = 1'b1;
         end else if (slot_dy_ff[i] > own_yc) begin
            dir[i][mrxy_pkg::PORT_N] = 1'b1;
         end else begin
            dir[i][mrxy_pkg::PORT_L] = 1'b1;
         end
      end
   end

   // Oldest stamp wins its output; the higher slot wins a tie
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         win[i] = slot_busy_ff[i];
         for (int j = 0; j < NP; j++) begin
            if (j != i && slot_busy_ff[j] && dir[j] == dir[i]) begin
               if (j < i) begin
                  if (slot_stamp_ff[i] > slot_stamp_ff[j]) begin
                     win[i] = 1'b0;
                  end
               end else begin
                  if (slot_stamp_ff[i] >= slot_stamp_ff[j]) begin
                     win[i] = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Gather the winner of each output
   always_comb begin
      for (int d = 0; d < NP; d++) begin
         has_win[d]   = 1'b0;
         w_dx[d]      = '0;
         w_dy[d]      = '0;
         w_payload[d] = '0;
         w_stamp[d]   = '0;
         for (int i = 0; i < NP; i++) begin
            if (win[i] && dir[i][d]) begin
               has_win[d]   = 1'b1;
               w_dx[d]      = slot_dx_ff[i];
               w_dy[d]      = slot_dy_ff[i];
               w_payload[d] = slot_payload_ff[i];
               w_stamp[d]   = slot_stamp_ff[i];
            end
         end
         emit[d] = has_win[d] && (!port_present_ff[d] || req_data.out_ready[d]);
      end
      for (int i = 0; i < NP; i++) begin
         free[i] = win[i] && ((dir[i] & emit) != '0);
      end
   end

   // Build the responses of the request
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int d = NP - 1; d >= 0; d--) begin
         new_lane[d]             = '0;
         new_lane[d].kind        = port_present_ff[d] ? mrxy_pkg::KIND_FWD
                                                      : mrxy_pkg::KIND_DROP;
         new_lane[d].out_port    = PW'(d);
         new_lane[d].out_dest_x  = CW'(w_dx[d]);
         new_lane[d].out_dest_y  = CW'(w_dy[d]);
         new_lane[d].out_payload = DW'(w_payload[d]);
         new_lane[d].out_stamp   = SW'(w_stamp[d]);
         new_lane[d].last        = emit[d] && !seen;
         seen                    = seen || emit[d];
      end
      new_valid = emit;
      if (!is_tick) begin
         for (int d = 0; d < NP; d++) begin
            new_lane[d] = '0;
         end
         new_lane[0].kind     = mrxy_pkg::KIND_RECV;
         new_lane[0].accepted = rec_ok;
         new_lane[0].last     = 1'b1;
         new_valid            = NP'(1);
      end else if (emit == '0) begin
         new_lane[0]      = '0;
         new_lane[0].kind = mrxy_pkg::KIND_NONE;
         new_lane[0].last = 1'b1;
         new_valid        = NP'(1);
      end
   end

   // Pick the lowest pending lane
   always_comb begin
      sel_item = '0;
      for (int d = 0; d < NP; d++) begin
         if (sel_oh[d]) begin
            sel_item = pend_ff[d];
         end
      end
   end

   // Next state of control registers
   always_comb begin
      cycle_count_in = cycle_count_ff;
      slot_busy_in   = slot_busy_ff | store_en;
      if (tick_accept) begin
         cycle_count_in = cycle_count_ff + 1'b1;
         slot_busy_in   = slot_busy_ff & ~free;
      end
      pend_valid_in = move ? (pend_valid_ff & ~sel_oh) : pend_valid_ff;
      if (req_accept) begin
         pend_valid_in = pend_valid_in | new_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff        <= '0;
         own_y_ff        <= '0;
         port_present_ff <= mrxy_pkg::PORT_PRESENT_RST;
         cycle_count_ff  <= '0;
         slot_busy_ff    <= '0;
         pend_valid_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cycle_count_ff <= cycle_count_in;
         slot_busy_ff   <= slot_busy_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mrxy_pkg::CSR_OWN_X:        own_x_ff        <= csr_data;
               mrxy_pkg::CSR_OWN_Y:        own_y_ff        <= csr_data;
               mrxy_pkg::CSR_PORT_PRESENT: port_present_ff <= csr_data[NP-1:0];
               default: ;
            endcase
         end
      end
   end

   // Slot contents; local requests take the cycle count as stamp
   always_ff @(posedge clock) begin
      for (int i = 0; i < NP; i++) begin
         if (store_en[i]) begin
            slot_dx_ff[i]      <= COORD_BITS'(req_data.dest_x);
            slot_dy_ff[i]      <= COORD_BITS'(req_data.dest_y);
            slot_payload_ff[i] <= PAYLOAD_BITS'(req_data.payload);
            slot_stamp_ff[i]   <= (i == mrxy_pkg::PORT_L) ? cycle_count_ff
                                                          : STAMP_BITS'(req_data.stamp_in);
         end
      end
   end

   // Response lanes and response register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int d = 0; d < NP; d++) begin
            pend_ff[d] <= new_lane[d];
         end
      end
      if (move) begin
         rsp_data_ff <= sel_item;
      end
   end

`ifndef SYNTHESIS
   logic [NP-1:0] pend_last;

   always_comb begin
      for (int d = 0; d < NP; d++) begin
         pend_last[d] = pend_ff[d].last;
      end
   end

   a_accept_fills_lanes: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pend_valid_ff != '0)
      else $error("accepted request left no response");

   a_one_last_pending: assert property (@(posedge clock) disable iff (reset)
      pend_any |-> $onehot(pend_last & pend_valid_ff))
      else $error("pending responses do not end in exactly one last");

   a_free_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !tick_accept |=> (($past(slot_busy_ff) & ~slot_busy_ff) == '0))
      else $error("slot freed without a tick");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> cycle_count_ff == STAMP_BITS'($past(cycle_count_ff) + 1'b1))
      else $error("cycle count did not advance on tick");
`endif

endmodule

`default_nettype wire
